// ===== rtl/gfd_pkg.sv =====
// Shared types, constants and a helper function for the gateway frame deframer.
// Used by the controller, the datapath and the top level; depends on nothing.
package gfd_pkg;

  localparam int BufDepth = 64;
  localparam int PtrW     = $clog2(BufDepth);
  localparam int CntW     = $clog2(BufDepth + 1);
  localparam int OffW     = (CntW > 7) ? CntW : 7;
  localparam int BodyW    = 6;
  localparam int CapW     = 7;

  localparam logic [7:0] StxByte      = 8'h55;
  localparam logic [7:0] EtxByte      = 8'h03;
  localparam logic [7:0] TypeTimesync = 8'h00;
  localparam logic [7:0] TypeRequest  = 8'h01;

  localparam int TsBody    = 13;
  localparam int SessHdr   = 5;
  localparam int HsHdr     = 3;
  localparam int TsFrame   = HsHdr + TsBody + 1;
  localparam int ResultCap = 64;
  localparam logic [BodyW-1:0] MaxBodyReset = BodyW'(16);

  typedef enum logic [3:0] {
    OFF_0, OFF_1, OFF_2, OFF_3, OFF_4, OFF_TS_END, OFF_ETX, OFF_IDX, OFF_BODY
  } rd_sel_e;

  typedef enum logic [1:0] {
    DROP_ONE, DROP_SCAN, DROP_FRAME
  } drop_sel_e;

  typedef struct packed {
    logic      in_ready;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      ld_b1;
    logic      ld_b2;
    logic      ld_type;
    logic      ld_seq;
    logic      ld_ts;
    logic      ld_len;
    logic      idx_init3;
    logic      idx_init0;
    logic      idx_inc;
    logic      drop;
    drop_sel_e drop_sel;
    logic      out_hdr;
    logic      out_body;
    logic      finish;
  } gfd_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_new_conn;
    logic phase;
    logic fill_zero;
    logic fill_ge_min;
    logic fill_ge_ts;
    logic b1_ts;
    logic len_gt_max;
    logic fill_lt_need;
    logic idx_ge_fill;
    logic scan_bad;
    logic scan_lim;
    logic cnt_fits;
    logic idx_last;
    logic bl_zero;
    logic type_keep;
    logic rd_stx;
    logic rd_etx;
    logic out_free;
  } gfd_stat_t;

  // Circular buffer address: base plus offset, folded once into the depth.
  function automatic logic [PtrW-1:0] wrap_add(logic [PtrW-1:0] base,
                                               logic [OffW-1:0] off);
    logic [OffW:0] s;
    s = (OffW+1)'(base) + (OffW+1)'(off);
    if (s >= (OffW+1)'(BufDepth)) begin
      s = s - (OffW+1)'(BufDepth);
    end
    return s[PtrW-1:0];
  endfunction

endpackage

// ===== rtl/gfd_ifs.sv =====
// Valid/ready channel interfaces for received bytes, results and configuration.
// Stand-alone; the field widths are fixed by the frame format.
interface gfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_connection;
  modport source (output valid, rx_byte, new_connection, input ready);
  modport sink (input valid, rx_byte, new_connection, output ready);
endinterface

interface gfd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] frame_type;
  logic [7:0] seq_number;
  logic [5:0] body_length;
  logic       compact_format;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, kind, frame_type, seq_number, body_length,
                  compact_format, data_byte, last, input ready);
  modport sink (input valid, kind, frame_type, seq_number, body_length,
                compact_format, data_byte, last, output ready);
endinterface

interface gfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/gfd_ctrl.sv =====
// Parse sequencer of the deframer: walks the buffer one read at a time.
// Depends on gfd_pkg for the command and status structs.
module gfd_ctrl
  import gfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gfd_stat_t stat_i,
  output gfd_cmd_t  cmd_o
);

  typedef enum logic [20:0] {
    S_IDLE      = 21'd1 << 0,
    S_LOOP      = 21'd1 << 1,
    S_HUNT_RD   = 21'd1 << 2,
    S_HUNT_CHK  = 21'd1 << 3,
    S_AFTER     = 21'd1 << 4,
    S_RD1       = 21'd1 << 5,
    S_RD2       = 21'd1 << 6,
    S_TS_ETX    = 21'd1 << 7,
    S_LEN       = 21'd1 << 8,
    S_S_ETX     = 21'd1 << 9,
    S_S_TYP     = 21'd1 << 10,
    S_S_SEQ     = 21'd1 << 11,
    S_SCAN_RD   = 21'd1 << 12,
    S_SCAN_CHK  = 21'd1 << 13,
    S_EMIT_CHK  = 21'd1 << 14,
    S_EMIT_HDR  = 21'd1 << 15,
    S_EMIT_RD   = 21'd1 << 16,
    S_EMIT_BODY = 21'd1 << 17,
    S_EMIT_DONE = 21'd1 << 18,
    S_FINISH    = 21'd1 << 19,
    S_SPARE     = 21'd1 << 20
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid && !stat_i.in_new_conn) begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        state_d = stat_i.fill_ge_min ? S_HUNT_RD : S_FINISH;
      end
      S_HUNT_RD: begin
        if (stat_i.fill_zero) begin
          state_d = S_AFTER;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = OFF_0;
          state_d      = S_HUNT_CHK;
        end
      end
      S_HUNT_CHK: begin
        if (stat_i.rd_stx) begin
          state_d = S_AFTER;
        end else begin
          cmd_o.drop     = 1'b1;
          cmd_o.drop_sel = DROP_ONE;
          state_d        = S_HUNT_RD;
        end
      end
      S_AFTER: begin
        if (stat_i.fill_ge_min) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = OFF_1;
          state_d      = S_RD1;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_RD1: begin
        cmd_o.ld_b1  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = OFF_2;
        state_d      = S_RD2;
      end
      S_RD2: begin
        cmd_o.ld_b2 = 1'b1;
        if (stat_i.phase) begin
          if (stat_i.b1_ts && stat_i.fill_ge_ts) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = OFF_TS_END;
            state_d      = S_TS_ETX;
          end else begin
            state_d = S_LEN;
          end
        end else if (stat_i.b1_ts) begin
          if (stat_i.fill_ge_ts) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = OFF_TS_END;
            state_d      = S_TS_ETX;
          end else begin
            state_d = S_FINISH;
          end
        end else begin
          cmd_o.idx_init3 = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_TS_ETX: begin
        if (stat_i.rd_etx) begin
          cmd_o.ld_ts = 1'b1;
          state_d     = S_EMIT_CHK;
        end else if (stat_i.phase) begin
          state_d = S_LEN;
        end else begin
          cmd_o.drop     = 1'b1;
          cmd_o.drop_sel = DROP_ONE;
          state_d        = S_LOOP;
        end
      end
      S_LEN: begin
        if (stat_i.len_gt_max) begin
          cmd_o.drop     = 1'b1;
          cmd_o.drop_sel = DROP_ONE;
          state_d        = S_LOOP;
        end else if (stat_i.fill_lt_need) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.ld_len = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = OFF_ETX;
          state_d      = S_S_ETX;
        end
      end
      S_S_ETX: begin
        if (stat_i.rd_etx) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = OFF_3;
          state_d      = S_S_TYP;
        end else begin
          cmd_o.drop     = 1'b1;
          cmd_o.drop_sel = DROP_ONE;
          state_d        = S_LOOP;
        end
      end
      S_S_TYP: begin
        cmd_o.ld_type = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = OFF_4;
        state_d       = S_S_SEQ;
      end
      S_S_SEQ: begin
        cmd_o.ld_seq = 1'b1;
        if (stat_i.type_keep) begin
          state_d = S_EMIT_CHK;
        end else begin
          cmd_o.drop     = 1'b1;
          cmd_o.drop_sel = DROP_FRAME;
          state_d        = S_LOOP;
        end
      end
      S_SCAN_RD: begin
        if (stat_i.idx_ge_fill) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = OFF_IDX;
          state_d      = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.rd_etx) begin
          cmd_o.drop     = 1'b1;
          cmd_o.drop_sel = stat_i.scan_bad ? DROP_ONE : DROP_SCAN;
          state_d        = S_LOOP;
        end else if (stat_i.scan_lim) begin
          cmd_o.drop     = 1'b1;
          cmd_o.drop_sel = DROP_ONE;
          state_d        = S_LOOP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_EMIT_CHK: begin
        state_d = stat_i.cnt_fits ? S_EMIT_HDR : S_FINISH;
      end
      S_EMIT_HDR: begin
        if (stat_i.out_free) begin
          cmd_o.out_hdr   = 1'b1;
          cmd_o.idx_init0 = 1'b1;
          state_d         = stat_i.bl_zero ? S_EMIT_DONE : S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = OFF_BODY;
        state_d      = S_EMIT_BODY;
      end
      S_EMIT_BODY: begin
        if (stat_i.out_free) begin
          cmd_o.out_body = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d        = stat_i.idx_last ? S_EMIT_DONE : S_EMIT_RD;
        end
      end
      S_EMIT_DONE: begin
        cmd_o.drop     = 1'b1;
        cmd_o.drop_sel = DROP_FRAME;
        state_d        = S_LOOP;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/gfd_dp.sv =====
// Datapath of the deframer: circular byte buffer, frame registers, result register
// and the body length limit register. Depends on gfd_pkg and the channel interfaces.
module gfd_dp
  import gfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gfd_in_if.sink    rx_i,
  gfd_out_if.source res_o,
  gfd_cfg_if.sink   cfg_i,
  input  gfd_cmd_t  cmd_i,
  output gfd_stat_t stat_o
);

  logic [7:0]       mem_q [BufDepth];
  logic [7:0]       rd_data_q;
  logic [PtrW-1:0]  head_q, head_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             phase_q, phase_d;
  logic             sync_q, sync_d;
  logic [BodyW-1:0] len_limit_q;
  logic [CapW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q;
  logic [OffW-1:0]  idx_q;
  logic [7:0]       b1_q, b2_q, type_q, seq_q;
  logic [BodyW-1:0] bl_q;
  logic             compact_q;

  logic             accept, append, clear, fill_full, out_free, out_load;
  logic [OffW-1:0]  fill_ext, wr_off, rd_off, drop_n, scan_len;
  logic [PtrW-1:0]  wr_addr, rd_addr;

  assign rx_i.ready  = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;
  assign accept      = rx_i.valid && cmd_i.in_ready;
  assign append      = accept && !rx_i.new_connection;
  assign clear       = accept && rx_i.new_connection;
  assign fill_full   = (fill_q == CntW'(BufDepth));
  assign fill_ext    = OffW'(fill_q);
  assign wr_off      = fill_full ? '0 : fill_ext;
  assign wr_addr     = wrap_add(fill_full ? '0 : head_q, wr_off);
  assign out_free    = !out_valid_q || res_o.ready;
  assign out_load    = cmd_i.out_hdr || cmd_i.out_body;
  assign scan_len    = idx_q - OffW'(HsHdr);

  always_comb begin
    case (cmd_i.rd_sel)
      OFF_0:      rd_off = '0;
      OFF_1:      rd_off = OffW'(1);
      OFF_2:      rd_off = OffW'(2);
      OFF_3:      rd_off = OffW'(3);
      OFF_4:      rd_off = OffW'(4);
      OFF_TS_END: rd_off = OffW'(TsFrame - 1);
      OFF_ETX:    rd_off = OffW'(SessHdr) + OffW'(b2_q[BodyW-1:0]);
      OFF_IDX:    rd_off = idx_q;
      OFF_BODY:   rd_off = (compact_q ? OffW'(HsHdr) : OffW'(SessHdr)) + idx_q;
      default:    rd_off = '0;
    endcase
  end
  assign rd_addr = wrap_add(head_q, rd_off);

  always_comb begin
    case (cmd_i.drop_sel)
      DROP_ONE:   drop_n = OffW'(1);
      DROP_SCAN:  drop_n = idx_q + OffW'(1);
      DROP_FRAME: drop_n = compact_q ? OffW'(TsFrame)
                                     : OffW'(SessHdr + 1) + OffW'(bl_q);
      default:    drop_n = OffW'(1);
    endcase
  end

  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    phase_d = phase_q;
    sync_d  = sync_q;
    cnt_d   = cnt_q;
    if (clear) begin
      fill_d  = '0;
      head_d  = '0;
      phase_d = 1'b0;
    end else if (append) begin
      if (fill_full) begin
        head_d = '0;
        fill_d = CntW'(1);
      end else begin
        fill_d = fill_q + CntW'(1);
      end
      cnt_d  = '0;
      sync_d = 1'b0;
    end else if (cmd_i.drop) begin
      if (drop_n >= fill_ext) begin
        fill_d = '0;
        head_d = '0;
      end else begin
        fill_d = fill_q - drop_n[CntW-1:0];
        head_d = wrap_add(head_q, drop_n);
      end
      if (cmd_i.drop_sel == DROP_FRAME && compact_q) begin
        sync_d = 1'b1;
      end
    end
    if (out_load) begin
      cnt_d = cnt_q + CapW'(1);
    end
    if (cmd_i.finish && sync_q) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      phase_q     <= 1'b0;
      sync_q      <= 1'b0;
      cnt_q       <= '0;
      len_limit_q <= MaxBodyReset;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      sync_q  <= sync_d;
      cnt_q   <= cnt_d;
      if (cfg_i.valid) begin
        len_limit_q <= cfg_i.data;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Buffer memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (append) begin
      mem_q[wr_addr] <= rx_i.rx_byte;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_b1)   b1_q   <= rd_data_q;
    if (cmd_i.ld_b2)   b2_q   <= rd_data_q;
    if (cmd_i.ld_type) type_q <= rd_data_q;
    if (cmd_i.ld_seq)  seq_q  <= rd_data_q;
    if (cmd_i.ld_ts) begin
      type_q    <= TypeTimesync;
      seq_q     <= b2_q;
      bl_q      <= BodyW'(TsBody);
      compact_q <= 1'b1;
    end
    if (cmd_i.ld_len) begin
      bl_q      <= b2_q[BodyW-1:0];
      compact_q <= 1'b0;
    end
    if (cmd_i.idx_init3) begin
      idx_q <= OffW'(HsHdr);
    end else if (cmd_i.idx_init0) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + OffW'(1);
    end
    if (cmd_i.out_hdr) begin
      res_o.kind           <= 1'b0;
      res_o.frame_type     <= type_q;
      res_o.seq_number     <= seq_q;
      res_o.body_length    <= bl_q;
      res_o.compact_format <= compact_q;
      res_o.data_byte      <= '0;
      res_o.last           <= 1'b0;
    end else if (cmd_i.out_body) begin
      res_o.kind      <= 1'b1;
      res_o.data_byte <= rd_data_q;
      res_o.last      <= stat_o.idx_last;
    end
  end

  assign res_o.valid = out_valid_q;

  always_comb begin
    stat_o.in_valid     = rx_i.valid;
    stat_o.in_new_conn  = rx_i.new_connection;
    stat_o.phase        = phase_q;
    stat_o.fill_zero    = (fill_q == '0);
    stat_o.fill_ge_min  = fill_ext >= (phase_q ? OffW'(SessHdr + 1) : OffW'(HsHdr));
    stat_o.fill_ge_ts   = fill_ext >= OffW'(TsFrame);
    stat_o.b1_ts        = (b1_q == TypeTimesync);
    stat_o.len_gt_max   = {b1_q, b2_q} > 16'(len_limit_q);
    stat_o.fill_lt_need = fill_ext < (OffW'(SessHdr + 1) + OffW'(b2_q[BodyW-1:0]));
    stat_o.idx_ge_fill  = idx_q >= fill_ext;
    stat_o.scan_bad     = scan_len > OffW'(len_limit_q);
    stat_o.scan_lim     = scan_len >= OffW'(len_limit_q);
    stat_o.cnt_fits     = (8'(cnt_q) + 8'd1 + 8'(bl_q)) <= 8'(ResultCap);
    stat_o.idx_last     = (idx_q + OffW'(1)) == OffW'(bl_q);
    stat_o.bl_zero      = (bl_q == '0);
    stat_o.type_keep    = (type_q == TypeTimesync) ||
                          ((type_q == TypeRequest) && (bl_q != '0));
    stat_o.rd_stx       = (rd_data_q == StxByte);
    stat_o.rd_etx       = (rd_data_q == EtxByte);
    stat_o.out_free     = out_free;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(BufDepth)) else $error("buffer fill beyond depth");
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < PtrW'(BufDepth - 1) || head_q == PtrW'(BufDepth - 1))
    else $error("head pointer out of range");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapW'(ResultCap)) else $error("too many results in one step");
  a_phase_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q) |-> $past(sync_q)) else $error("session phase without timesync");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result register overwritten");

endmodule

// ===== rtl/gateway_frame_deframer_top.sv =====
// Top level of the gateway frame deframer: sequencer plus datapath.
// Depends on gfd_pkg, gfd_ifs, gfd_ctrl and gfd_dp.
// The block takes a new byte only once the parse of the previous one is finished; the
// parse hunts byte by byte for the start byte and scans byte by byte for the end byte.
// After the last byte is taken, a header is loaded (timesync or length field path) and
// each body byte follows it, held by any output stall. Reset (rst_ni low, asynchronous):
// buffer empty, handshake phase, body length limit 16.
module gateway_frame_deframer_top
  import gfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gfd_in_if.sink    rx_i,
  gfd_out_if.source res_o,
  gfd_cfg_if.sink   cfg_i
);

  // The sequencer drives one command set per cycle; the datapath answers with
  // the compares that steer the parse loop.
  gfd_cmd_t  cmd;
  gfd_stat_t stat;

  gfd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  gfd_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

// ===== sim/gfd_tb_ifs.sv =====
// Testbench timing constant; the channel interfaces come from rtl/gfd_ifs.sv.
// Depends on nothing.
package gfd_tb_ifs_pkg;
  localparam int SimClkPeriodNs = 10;
endpackage

// ===== sim/tb_top.sv =====
// Testbench for the gateway frame deframer: drives received bytes, connection
// restarts and body limit writes, predicts frames in a behavioral deframer, and
// checks every result. Depends on gfd_pkg, gfd_tb_ifs_pkg, gfd_ifs and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gfd_pkg::*;
  import gfd_tb_ifs_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_type;
    logic [7:0] seq_number;
    logic [5:0] body_length;
    logic       compact_format;
    logic [7:0] data_byte;
    logic       last;
  } frame_res_t;

  typedef struct {
    logic [7:0] rx_byte;
    logic       new_connection;
    bit         has_hdr;
    frame_res_t hdr;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #(SimClkPeriodNs / 2) clk_i = ~clk_i;

  gfd_in_if  rx_if();
  gfd_out_if res_if();
  gfd_cfg_if cfg_if();

  gateway_frame_deframer_top dut (
    .clk_i (clk_i), .rst_ni(rst_ni),
    .rx_i  (rx_if.sink), .res_o(res_if.source), .cfg_i(cfg_if.sink)
  );

  // Predictor state: a linear copy of the receive buffer.
  logic [7:0] rx_buf[BufDepth];
  int unsigned rx_fill;
  bit          in_session;
  logic [5:0]  body_limit;
  frame_res_t  frame_q[$];
  int unsigned step_cnt;
  int          err_cnt;
  int unsigned cycle_cnt;
  bit          quiet;

  task automatic report(input string what);
    err_cnt++;
    $display("tb_top: mismatch: %s", what);
  endtask

  function automatic void drop_bytes(input int unsigned n);
    if (n >= rx_fill) begin
      rx_fill = 0;
      return;
    end
    for (int unsigned k = 0; k < rx_fill - n; k++) rx_buf[k] = rx_buf[k + n];
    rx_fill -= n;
  endfunction

  function automatic void seek_stx();
    int unsigned k;
    k = 0;
    while (k < rx_fill && rx_buf[k] != StxByte) k++;
    drop_bytes(k);
  endfunction

  // Queue a header and its body bytes; refuses when the step would overflow.
  function automatic bit push_frame(input logic [7:0] ty, input logic [7:0] sq,
                                    input int unsigned bl, input bit cmp,
                                    input int unsigned at);
    frame_res_t r;
    if (step_cnt + 1 + bl > ResultCap) return 0;
    r = '{kind: 1'b0, frame_type: ty, seq_number: sq, body_length: 6'(bl),
          compact_format: cmp, data_byte: 8'h00, last: 1'b0};
    frame_q.push_back(r);
    for (int unsigned j = 0; j < bl; j++) begin
      r.kind = 1'b1;
      r.data_byte = rx_buf[at + j];
      r.last = (j + 1 == bl);
      frame_q.push_back(r);
    end
    step_cnt += 1 + bl;
    return 1;
  endfunction

  function automatic void deframe_handshake();
    bit synced;
    bit hit, bad;
    int unsigned bl;
    synced = 0;
    while (rx_fill >= HsHdr) begin
      seek_stx();
      if (rx_fill < HsHdr) break;
      if (rx_buf[1] == TypeTimesync) begin
        if (rx_fill < TsFrame) break;
        if (rx_buf[TsFrame-1] != EtxByte) begin
          drop_bytes(1);
          continue;
        end
        if (!push_frame(TypeTimesync, rx_buf[2], TsBody, 1, HsHdr)) break;
        synced = 1;
        drop_bytes(TsFrame);
        continue;
      end
      hit = 0; bad = 0; bl = 0;
      for (int unsigned k = HsHdr; k < rx_fill; k++) begin
        if (rx_buf[k] == EtxByte) begin
          bl = k - HsHdr;
          if (bl > body_limit) bad = 1; else hit = 1;
          break;
        end
        if (k - HsHdr >= body_limit) begin
          bad = 1;
          break;
        end
      end
      if (bad) begin
        drop_bytes(1);
        continue;
      end
      if (!hit) break;
      drop_bytes(HsHdr + bl + 1);
    end
    if (synced) in_session = 1;
  endfunction

  function automatic void deframe_session();
    int unsigned bl, need;
    while (rx_fill >= SessHdr + 1) begin
      seek_stx();
      if (rx_fill < SessHdr + 1) break;
      if (rx_buf[1] == TypeTimesync && rx_fill >= TsFrame && rx_buf[TsFrame-1] == EtxByte)
      begin
        if (!push_frame(TypeTimesync, rx_buf[2], TsBody, 1, HsHdr)) break;
        drop_bytes(TsFrame);
        continue;
      end
      bl = {rx_buf[1], rx_buf[2]};
      if (bl > body_limit) begin
        drop_bytes(1);
        continue;
      end
      need = SessHdr + bl + 1;
      if (rx_fill < need) break;
      if (rx_buf[SessHdr + bl] != EtxByte) begin
        drop_bytes(1);
        continue;
      end
      if (rx_buf[3] == TypeTimesync || (rx_buf[3] == TypeRequest && bl > 0)) begin
        if (!push_frame(rx_buf[3], rx_buf[4], bl, 0, SessHdr)) break;
      end
      drop_bytes(need);
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic nc);
    step_cnt = 0;
    if (nc) begin
      rx_fill = 0;
      in_session = 0;
      return;
    end
    if (rx_fill >= BufDepth) rx_fill = 0;
    rx_buf[rx_fill] = b;
    rx_fill++;
    if (in_session) deframe_session(); else deframe_handshake();
  endfunction

  // Sends one request on the byte channel, with an optional random gap first.
  // Valid stays high on return; the caller drops it before any wait.
  task automatic send_byte(input logic [7:0] b, input logic nc);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.new_connection <= nc;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    predict_byte(b, nc);
  endtask

  task automatic send_list(input logic [7:0] bytes[$]);
    foreach (bytes[k]) send_byte(bytes[k], 1'b0);
  endtask

  // Waits until every expected result is out and the block is idle again.
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (frame_q.size() != 0 || !rx_if.ready) @(posedge clk_i);
  endtask

  task automatic drain_and_set(input logic [5:0] lim);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= lim;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    body_limit = lim;
  endtask

  // Random session frame: mostly well formed, sometimes corrupted.
  task automatic send_session_frame();
    logic [7:0] f[$];
    int unsigned bl;
    bl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
    f = {StxByte, 8'h00, 8'(bl), ($urandom_range(0, 3) == 0) ? TypeTimesync : TypeRequest,
         8'($urandom)};
    for (int unsigned k = 0; k < bl; k++) f.push_back(8'($urandom));
    f.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : EtxByte);
    if ($urandom_range(0, 7) == 0) f[1] = 8'($urandom);
    send_list(f);
  endtask

  task automatic send_timesync(input bit broken);
    logic [7:0] f[$];
    f = {StxByte, TypeTimesync, 8'($urandom)};
    repeat (TsBody) f.push_back(8'($urandom));
    f.push_back(broken ? 8'h04 : EtxByte);
    send_list(f);
  endtask

  // Result checker: random stalls, compares against the oldest expectation.
  always @(posedge clk_i) begin
    frame_res_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.kind, res_if.frame_type, res_if.seq_number, res_if.body_length,
              res_if.compact_format, res_if.data_byte, res_if.last};
      if (frame_q.size() == 0) report($sformatf("unexpected result %h", got));
      else begin
        want = frame_q.pop_front();
        if (got.kind != want.kind) report("kind");
        if (got.frame_type != want.frame_type) report("frame_type");
        if (got.seq_number != want.seq_number) report("seq_number");
        if (got.body_length != want.body_length) report("body_length");
        if (got.compact_format != want.compact_format) report("compact_format");
        if (got.data_byte != want.data_byte) report("data_byte");
        if (got.last != want.last) report("last");
      end
    end
  end

  int stall_left;
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) res_if.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 12);
      res_if.ready <= 1'b0;
    end else res_if.ready <= 1'b1;
  end

  // Watchdog: ends the run at a generous cycle limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 900000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Directed table: leading garbage, a handshake timesync and a new connection.
  stim_row_t dir_rows[$];

  initial begin
    frame_res_t hdr;
    rx_fill = 0; in_session = 0; body_limit = MaxBodyReset; err_cnt = 0;
    cycle_cnt = 0; quiet = 0; stall_left = 0;
    rx_if.valid = 0; rx_if.rx_byte = 0; rx_if.new_connection = 0;
    cfg_if.valid = 0; cfg_if.data = 0; res_if.ready = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Leading garbage, then a handshake timesync with seq 0xFF: header known.
    hdr = '{1'b0, TypeTimesync, 8'hFF, 6'd13, 1'b1, 8'h00, 1'b0};
    dir_rows = '{'{8'hFF, 0, 0, '0}, '{8'h00, 0, 0, '0}, '{StxByte, 0, 0, '0},
                 '{TypeTimesync, 0, 0, '0}, '{8'hFF, 0, 0, '0}};
    for (int k = 0; k < TsBody; k++) dir_rows.push_back('{8'(k * 19 + 1), 0, 0, '0});
    dir_rows.push_back('{EtxByte, 0, 1, hdr});
    dir_rows.push_back('{8'hAA, 1, 0, '0});
    foreach (dir_rows[k]) begin
      send_byte(dir_rows[k].rx_byte, dir_rows[k].new_connection);
      if (dir_rows[k].has_hdr && (frame_q.size() < 14 || frame_q[0] != dir_rows[k].hdr))
        report("directed timesync header");
    end

    // Handshake request frame, then a body past the limit, then a broken and a good timesync.
    send_list('{StxByte, TypeRequest, 8'h01, 8'h10, 8'h20, EtxByte});
    drain_and_set(6'd1);
    send_list('{StxByte, TypeRequest, 8'h02, 8'h10, 8'h20, EtxByte});
    send_timesync(1);
    send_timesync(0);
    // Session: empty timesync, request with body, bad length, empty request.
    send_list('{StxByte, 8'h00, 8'h00, TypeTimesync, 8'h33, EtxByte});
    send_list('{StxByte, 8'h00, 8'h01, TypeRequest, 8'h44, 8'h80, EtxByte});
    send_list('{StxByte, 8'hFF, 8'hFF, TypeRequest, 8'h00, EtxByte});
    drain_and_set(6'd57);
    send_list('{StxByte, 8'h00, 8'h00, TypeRequest, 8'h45, EtxByte});
    send_session_frame();
    send_byte(8'h00, 1'b1);

    // Random part across several limits, including the extremes.
    for (int ph = 0; ph < 3; ph++) begin
      drain_and_set(ph == 0 ? 6'd57 : ph == 1 ? 6'd1 : 6'($urandom_range(2, 56)));
      send_timesync($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: send_byte(8'($urandom), 1'b0);
        1: send_timesync($urandom_range(0, 1));
        2: if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), 1'b1);
        default: send_session_frame();
      endcase
    end
    // Final part: no idling on either side.
    quiet = 1;
    send_timesync(0);
    send_session_frame();

    wait_idle();
    repeat (400) @(posedge clk_i);
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
